// File: design/sbck_pkg.sv
// Shared types and constants for the sprite blitter with clipping and color key.
`default_nettype none

package sbck_pkg;

  // Widths fixed by the pixel and frame buffer formats.
  localparam int PIX_W        = 16;
  localparam int ADDR_W       = 17;
  localparam int REG_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - ADDR_W - PIX_W;

  // Pixel value that marks a transparent sprite pixel.
  localparam logic [PIX_W-1:0] KEY_TRANSPARENT = 16'h0001;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 2'd0,
    REG_ORIGIN_Y      = 2'd1,
    REG_SPRITE_WIDTH  = 2'd2,
    REG_SPRITE_HEIGHT = 2'd3
  } cfg_reg_t;

  // Raw configuration register contents.
  typedef struct packed {
    logic signed [REG_W-1:0] origin_x;
    logic signed [REG_W-1:0] origin_y;
    logic [REG_W-1:0]        sprite_width;
    logic [REG_W-1:0]        sprite_height;
  } cfg_regs_t;

endpackage

`default_nettype wire

// File: design/sprite_blit_clip_colour_key_unit.sv
// Top level of the sprite blitter with clipping and color key.
//
//   Channel   Dir  Ports                             Word
//   s_*       in   s_tvalid s_tready s_tdata         sprite pixel
//   m_*       out  m_tvalid m_tready m_tdata ...     write enable, address, pixel, last
//   cfg_*     in   cfg_we cfg_index cfg_data         origin x/y, sprite width/height
//
// Every input word produces one output word via the position and output registers.
// One word per clock is sustained while m_tready is high; the two pipeline registers
// hold up to two words. Reset clears valid flags, counters and origin, size to one.
// A stall on m_tready holds the output word and backs up into s_tready once
// both stages are full.
`default_nettype none

module sprite_blit_clip_colour_key_unit #(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 240,
  parameter int MAX_SPRITE_DIM = 512
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  // s_tdata: [15:0] sprite_pixel
  input  wire logic [sbck_pkg::IN_TDATA_W-1:0]     s_tdata,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  // m_tdata: [16:0] write_address, [32:17] write_pixel, [39:33] zero
  output      logic [sbck_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tuser: [0] write_enable
  output      logic                                m_tuser,
  output      logic                                m_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [sbck_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sbck_pkg::REG_W-1:0]          cfg_data
);

  localparam int XAW = $clog2(SCREEN_WIDTH);
  localparam int YAW = $clog2(SCREEN_HEIGHT);

  sbck_pkg::cfg_regs_t             regs;
  logic                            s1_valid;
  logic                            s1_ready;
  logic                            s1_we;
  logic [XAW-1:0]                  s1_x;
  logic [YAW-1:0]                  s1_y;
  logic [sbck_pkg::PIX_W-1:0]      s1_pixel;
  logic                            s1_last;
  logic [sbck_pkg::ADDR_W-1:0]     write_address;
  logic [sbck_pkg::PIX_W-1:0]      write_pixel;

  sbck_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  sbck_pos #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_pixel (s_tdata[sbck_pkg::PIX_W-1:0]),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_we    (s1_we),
    .s1_x     (s1_x),
    .s1_y     (s1_y),
    .s1_pixel (s1_pixel),
    .s1_last  (s1_last)
  );

  sbck_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_we       (s1_we),
    .s1_x        (s1_x),
    .s1_y        (s1_y),
    .s1_pixel    (s1_pixel),
    .s1_last     (s1_last),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_we      (m_tuser),
    .out_address (write_address),
    .out_pixel   (write_pixel),
    .out_last    (m_tlast)
  );

  // Pack the output word, address in the low bits.
  assign m_tdata = {{sbck_pkg::OUT_PAD_W{1'b0}}, write_pixel, write_address};

endmodule

`default_nettype wire

// File: design/sbck_cfg.sv
// Configuration register file for the sprite blitter.
`default_nettype none

module sbck_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [sbck_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sbck_pkg::REG_W-1:0]        cfg_data,
  output sbck_pkg::cfg_regs_t                    regs
);

  // Register writes; origin resets to zero, sprite size to one by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x      <= '0;
      regs.origin_y      <= '0;
      regs.sprite_width  <= sbck_pkg::REG_W'(1);
      regs.sprite_height <= sbck_pkg::REG_W'(1);
    end else if (cfg_we) begin
      case (sbck_pkg::cfg_reg_t'(cfg_index))
        sbck_pkg::REG_ORIGIN_X:      regs.origin_x      <= $signed(cfg_data);
        sbck_pkg::REG_ORIGIN_Y:      regs.origin_y      <= $signed(cfg_data);
        sbck_pkg::REG_SPRITE_WIDTH:  regs.sprite_width  <= cfg_data;
        sbck_pkg::REG_SPRITE_HEIGHT: regs.sprite_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/sbck_pos.sv
// Position counters, screen clipping and transparency test; first pipeline register.
`default_nettype none

module sbck_pos #(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 240,
  parameter int MAX_SPRITE_DIM = 512,
  localparam int XAW = $clog2(SCREEN_WIDTH),
  localparam int YAW = $clog2(SCREEN_HEIGHT)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sbck_pkg::cfg_regs_t           regs,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [sbck_pkg::PIX_W-1:0]    in_pixel,
  output      logic                          s1_valid,
  input  wire logic                          s1_ready,
  output      logic                          s1_we,
  output      logic [XAW-1:0]                s1_x,
  output      logic [YAW-1:0]                s1_y,
  output      logic [sbck_pkg::PIX_W-1:0]    s1_pixel,
  output      logic                          s1_last
);

  // Counter width holds the largest position, dimension width the largest size.
  localparam int CW  = $clog2(MAX_SPRITE_DIM);
  localparam int DW  = $clog2(MAX_SPRITE_DIM + 1);
  localparam int SW0 = $clog2(SCREEN_WIDTH + 1) + 1;
  localparam int SH0 = $clog2(SCREEN_HEIGHT + 1) + 1;
  localparam int XW1 = (CW + 2 > sbck_pkg::REG_W + 1) ? CW + 2 : sbck_pkg::REG_W + 1;
  localparam int XW2 = (XW1 > SW0) ? XW1 : SW0;
  localparam int XW  = (XW2 > SH0) ? XW2 : SH0;

  logic [CW-1:0]        column_count;
  logic [CW-1:0]        row_count;
  logic [DW-1:0]        w_eff;
  logic [DW-1:0]        h_eff;
  logic signed [XW-1:0] x_pos;
  logic signed [XW-1:0] y_pos;
  logic                 on_screen;
  logic                 we;
  logic                 col_end;
  logic                 row_end;
  logic                 accept;

  // A size of zero acts as one; a size above the maximum acts as the maximum.
  function automatic logic [DW-1:0] eff_dim(input logic [sbck_pkg::REG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if ({1'b0, v} > (sbck_pkg::REG_W + 1)'(MAX_SPRITE_DIM)) begin
      r = DW'(MAX_SPRITE_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // Screen coordinates of the current pixel and the clip and key tests.
  always_comb begin
    w_eff     = eff_dim(regs.sprite_width);
    h_eff     = eff_dim(regs.sprite_height);
    x_pos     = XW'(regs.origin_x) + XW'($signed({1'b0, column_count}));
    y_pos     = XW'(regs.origin_y) + XW'($signed({1'b0, row_count}));
    on_screen = !x_pos[XW-1] && (x_pos < XW'(SCREEN_WIDTH)) &&
                !y_pos[XW-1] && (y_pos < XW'(SCREEN_HEIGHT));
    we        = on_screen && (in_pixel != sbck_pkg::KEY_TRANSPARENT);
    col_end   = ((CW + 1)'(column_count) + (CW + 1)'(1)) >= (CW + 1)'(w_eff);
    row_end   = ((CW + 1)'(row_count) + (CW + 1)'(1)) >= (CW + 1)'(h_eff);
  end

  // Sprite position counters, wrapping after the final pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Stage payload; the pixel is zeroed when no write takes place.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_we    <= we;
      s1_x     <= x_pos[XAW-1:0];
      s1_y     <= y_pos[YAW-1:0];
      s1_pixel <= we ? in_pixel : '0;
      s1_last  <= col_end && row_end;
    end
  end

endmodule

`default_nettype wire

// File: design/sbck_addr.sv
// Frame buffer address computation and the output register.
`default_nettype none

module sbck_addr #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  localparam int XAW = $clog2(SCREEN_WIDTH),
  localparam int YAW = $clog2(SCREEN_HEIGHT)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s1_valid,
  output      logic                          s1_ready,
  input  wire logic                          s1_we,
  input  wire logic [XAW-1:0]                s1_x,
  input  wire logic [YAW-1:0]                s1_y,
  input  wire logic [sbck_pkg::PIX_W-1:0]    s1_pixel,
  input  wire logic                          s1_last,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_we,
  output      logic [sbck_pkg::ADDR_W-1:0]   out_address,
  output      logic [sbck_pkg::PIX_W-1:0]    out_pixel,
  output      logic                          out_last
);

  logic [31:0] addr_full;

  assign s1_ready = !out_valid || out_ready;

  // Row times screen width plus column, kept to the address width.
  assign addr_full = 32'(s1_y) * 32'(SCREEN_WIDTH) + 32'(s1_x);

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  // Output word; the address is zero when no write takes place.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      out_we      <= s1_we;
      out_address <= s1_we ? addr_full[sbck_pkg::ADDR_W-1:0] : '0;
      out_pixel   <= s1_pixel;
      out_last    <= s1_last;
    end
  end

endmodule

`default_nettype wire

// File: design/sbck_chk.sv
// Port-level checker for the sprite blitter, bound to the top level.
`default_nettype none

module sbck_chk #(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 240
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [sbck_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire logic                              m_tuser,
  input wire logic                              m_tlast
);

  // The output pipeline is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // A stalled output word holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled output word changed");

  // A skipped pixel carries zero address and zero pixel.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("skipped pixel has nonzero address or pixel");

  // A written pixel lands inside the frame buffer and is never the key.
  a_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (32'(m_tdata[sbck_pkg::ADDR_W-1:0]) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)) &&
      (m_tdata[sbck_pkg::ADDR_W +: sbck_pkg::PIX_W] != sbck_pkg::KEY_TRANSPARENT))
    else $error("written pixel outside the frame or transparent");

endmodule

bind sprite_blit_clip_colour_key_unit sbck_chk #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sbck_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
